// ===== src/jsm_pkg.sv =====
// Shared types, constants and register map of the joystick wheel mixer.
package jsm_pkg;

   // Full-scale stick magnitude used by every linear map.
   localparam int FULL_SCALE = 125;

   // Divide by FULL_SCALE as multiply by ceil(2^DIV_SHIFT / FULL_SCALE), then shift.
   // The result is exact for every dividend below 2^DIV_IN_W.
   localparam int DIV_SHIFT  = 26;
   localparam int DIV_IN_W   = 19;
   localparam int RECIP_W    = 20;
   localparam int DIV_PROD_W = DIV_IN_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

   // Register map, word index = paddr[3:2].
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_DEAD_BAND    = 2'd0;
   localparam logic [1:0] CSR_PULSE_LOW    = 2'd1;
   localparam logic [1:0] CSR_PULSE_CENTRE = 2'd2;
   localparam logic [1:0] CSR_PULSE_HIGH   = 2'd3;

   localparam logic [6:0]  DEAD_BAND_RST    = 7'd4;
   localparam logic [11:0] PULSE_LOW_RST    = 12'd1000;
   localparam logic [11:0] PULSE_CENTRE_RST = 12'd1500;
   localparam logic [11:0] PULSE_HIGH_RST   = 12'd1950;

   // How one wheel value is mapped.
   typedef enum logic [1:0] {
      OP_CENTRE,   // constant pulse_centre
      OP_FWD,      // magnitude onto centre..high
      OP_REV,      // negated magnitude onto low..centre
      OP_FULL      // signed difference onto low..high
   } jsm_op_type;

   // One wheel's pending map: operand is already shifted by the map's lower bound.
   typedef struct packed {
      jsm_op_type        op;
      logic signed [9:0] operand;
   } jsm_term_type;

   // Load enables of the stages after decode.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } jsm_adv_type;

endpackage

// ===== src/jsm_decode.sv =====
// Stage 1: stick case decode and per-wheel map selection.
module jsm_decode (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [7:0]             left_horizontal,
   input  logic signed [7:0]             left_vertical,
   input  logic signed [7:0]             right_horizontal,
   input  logic                          force_stop,
   input  logic [6:0]                    dead_band,
   output jsm_pkg::jsm_term_type [3:0]   terms_ff
);

   jsm_pkg::jsm_term_type [3:0] terms_in;

   logic signed [8:0] lx9, ly9, rx9, lx1, ly1, dz9, ndz9;
   logic              lxp, lxn, lxz, lyp, lyn, lyz;
   logic [7:0]        m_rx, m_lx, m_lx1, m_ly, m_ly1;
   logic [7:0]        h_pp, h_np, h_pn;

   function automatic logic [7:0] mag(input logic signed [8:0] v);
      logic signed [8:0] a;
      a = (v < 0) ? -v : v;
      return a[7:0];
   endfunction

   function automatic jsm_pkg::jsm_term_type t_fwd(input logic [7:0] m);
      jsm_pkg::jsm_term_type t;
      t.op      = jsm_pkg::OP_FWD;
      t.operand = $signed({2'b00, m});
      return t;
   endfunction

   function automatic jsm_pkg::jsm_term_type t_rev(input logic [7:0] m);
      jsm_pkg::jsm_term_type t;
      t.op      = jsm_pkg::OP_REV;
      t.operand = 10'(jsm_pkg::FULL_SCALE) - $signed({2'b00, m});
      return t;
   endfunction

   function automatic jsm_pkg::jsm_term_type t_full(input logic [7:0] a, input logic [7:0] b);
      jsm_pkg::jsm_term_type t;
      t.op      = jsm_pkg::OP_FULL;
      t.operand = $signed({2'b00, a}) - $signed({2'b00, b}) + 10'(jsm_pkg::FULL_SCALE);
      return t;
   endfunction

   function automatic jsm_pkg::jsm_term_type t_mid();
      jsm_pkg::jsm_term_type t;
      t.op      = jsm_pkg::OP_CENTRE;
      t.operand = '0;
      return t;
   endfunction

   assign lx9  = {left_horizontal[7], left_horizontal};
   assign ly9  = {left_vertical[7], left_vertical};
   assign rx9  = {right_horizontal[7], right_horizontal};
   assign lx1  = lx9 + 9'sd1;
   assign ly1  = ly9 + 9'sd1;
   assign dz9  = $signed({2'b00, dead_band});
   assign ndz9 = -dz9;

   assign lxp = lx9 > dz9;
   assign lxn = lx9 < ndz9;
   assign lxz = (lx9 < dz9) && (lx9 > ndz9);
   assign lyp = ly9 > dz9;
   assign lyn = ly9 < ndz9;
   assign lyz = (ly9 < dz9) && (ly9 > ndz9);

   assign m_rx  = mag(rx9);
   assign m_lx  = mag(lx9);
   assign m_lx1 = mag(lx1);
   assign m_ly  = mag(ly9);
   assign m_ly1 = mag(ly1);

   // Half-sums, floor of non-negative values.
   assign h_pp = 8'(({1'b0, m_lx1} + {1'b0, m_ly1}) >> 1);
   assign h_np = 8'(({1'b0, m_lx}  + {1'b0, m_ly1}) >> 1);
   assign h_pn = 8'(({1'b0, m_lx1} + {1'b0, m_ly})  >> 1);

   // Wheel order: front left, front right, back left, back right.
   always_comb begin
      terms_in = {4{t_mid()}};
      if (rx9 > dz9) begin
         terms_in = {t_rev(m_rx), t_fwd(m_rx), t_fwd(m_rx), t_rev(m_rx)};
      end else if (rx9 < ndz9) begin
         terms_in = {t_fwd(m_rx), t_rev(m_rx), t_rev(m_rx), t_fwd(m_rx)};
      end else if (lxp && lyp) begin
         terms_in = {t_full(m_lx1, m_ly1), t_fwd(h_pp), t_rev(h_pp), t_full(m_ly1, m_lx1)};
      end else if (lyp && lxz) begin
         terms_in = {t_rev(m_ly1), t_fwd(m_ly1), t_rev(m_ly1), t_fwd(m_ly1)};
      end else if (lxn && lyp) begin
         terms_in = {t_rev(h_np), t_full(m_ly1, m_lx), t_full(m_lx, m_ly1), t_fwd(h_np)};
      end else if (lxp && lyz) begin
         terms_in = {t_fwd(m_lx1), t_fwd(m_lx1), t_rev(m_lx1), t_rev(m_lx1)};
      end else if (lxn && lyz) begin
         terms_in = {t_rev(m_lx1), t_rev(m_lx1), t_fwd(m_lx1), t_fwd(m_lx1)};
      end else if (lxp && lyn) begin
         terms_in = {t_fwd(h_pn), t_full(m_lx1, m_ly), t_full(m_ly, m_lx1), t_rev(h_pn)};
      end else if (lyn && lxz) begin
         terms_in = {t_fwd(m_ly1), t_rev(m_ly1), t_fwd(m_ly1), t_rev(m_ly1)};
      end else if (lxn && lyn) begin
         terms_in = {t_full(m_ly1, m_lx), t_rev(h_np), t_fwd(h_np), t_full(m_lx, m_ly1)};
      end
      if (force_stop) begin
         terms_in = {4{t_mid()}};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

endmodule

// ===== src/jsm_wheel_scale.sv =====
// Stages 2 to 4 of one wheel: span multiply, divide by full scale, offset and clamp.
module jsm_wheel_scale (
   input  logic                   clock,
   input  jsm_pkg::jsm_adv_type   adv,
   input  jsm_pkg::jsm_term_type  term,
   input  logic [11:0]            pulse_low,
   input  logic [11:0]            pulse_centre,
   input  logic [11:0]            pulse_high,
   output logic [11:0]            wheel_ff
);

   // Stage 2
   logic signed [12:0]  span;
   logic signed [22:0]  prod_in, prod_ff;
   jsm_pkg::jsm_op_type op2_ff, op3_ff;

   // Stage 3
   logic [21:0]                      nabs;
   logic [jsm_pkg::DIV_IN_W-1:0]     ndiv;
   logic [jsm_pkg::DIV_PROD_W-1:0]   qprod;
   logic [12:0]                      quot_in, quot_ff;
   logic                             neg_ff;

   // Stage 4
   logic signed [13:0] squot;
   logic signed [14:0] base, value, low15, high15;
   logic [11:0]        wheel_in;

   always_comb begin
      case (term.op)
         jsm_pkg::OP_FWD: span = $signed({1'b0, pulse_high}) - $signed({1'b0, pulse_centre});
         jsm_pkg::OP_REV: span = $signed({1'b0, pulse_centre}) - $signed({1'b0, pulse_low});
         default:         span = $signed({1'b0, pulse_high}) - $signed({1'b0, pulse_low});
      endcase
   end

   assign prod_in = 23'(term.operand) * 23'(span);

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         prod_ff <= prod_in;
         op2_ff  <= term.op;
      end
   end

   // Truncate toward zero: divide the magnitude, restore the sign later.
   // The low..high map divides by twice full scale; halve first.
   assign nabs    = prod_ff[22] ? 22'(-prod_ff) : 22'(prod_ff);
   assign ndiv    = (op2_ff == jsm_pkg::OP_FULL) ? nabs[jsm_pkg::DIV_IN_W:1]
                                                 : nabs[jsm_pkg::DIV_IN_W-1:0];
   assign qprod   = jsm_pkg::DIV_PROD_W'(ndiv) * jsm_pkg::DIV_PROD_W'(jsm_pkg::RECIP);
   assign quot_in = qprod[jsm_pkg::DIV_SHIFT +: 13];

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         quot_ff <= quot_in;
         neg_ff  <= prod_ff[22];
         op3_ff  <= op2_ff;
      end
   end

   assign squot  = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
   assign base   = (op3_ff == jsm_pkg::OP_FWD) ? $signed({3'b000, pulse_centre})
                                               : $signed({3'b000, pulse_low});
   assign value  = (op3_ff == jsm_pkg::OP_CENTRE) ? $signed({3'b000, pulse_centre})
                                                  : base + 15'(squot);
   assign low15  = $signed({3'b000, pulse_low});
   assign high15 = $signed({3'b000, pulse_high});

   // Floor first, then ceiling.
   always_comb begin
      if (value < low15) begin
         wheel_in = pulse_low;
      end else if (value > high15) begin
         wheel_in = pulse_high;
      end else begin
         wheel_in = value[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         wheel_ff <= wheel_in;
      end
   end

endmodule

// ===== src/joystick_to_four_wheel_pulse_mixer.sv =====
// Top level: joystick sample to four clamped wheel pulse widths, with register port.
// Four registered stages (decode, span multiply, reciprocal divide, offset and clamp)
// each advance whenever the stage after is free. Throughput: one word per cycle
// while rsp_ready does not stall the output.
// Reset: synchronous, active high; empties the pipeline and loads the register
// defaults (dead band 4, pulses 1000 / 1500 / 1950).
module joystick_to_four_wheel_pulse_mixer (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [7:0] req_left_horizontal,
   input  logic signed [7:0] req_left_vertical,
   input  logic signed [7:0] req_right_horizontal,
   input  logic              req_force_stop,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_wheel_front_left,
   output logic [11:0]       rsp_wheel_front_right,
   output logic [11:0]       rsp_wheel_back_left,
   output logic [11:0]       rsp_wheel_back_right,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jsm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [6:0]  dead_band_ff, dead_band_in;
   logic [11:0] pulse_low_ff, pulse_low_in;
   logic [11:0] pulse_centre_ff, pulse_centre_in;
   logic [11:0] pulse_high_ff, pulse_high_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   // Write the addressed register, hold the others.
   always_comb begin
      dead_band_in    = dead_band_ff;
      pulse_low_in    = pulse_low_ff;
      pulse_centre_in = pulse_centre_ff;
      pulse_high_in   = pulse_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            jsm_pkg::CSR_DEAD_BAND:    dead_band_in    = csr_pwdata[6:0];
            jsm_pkg::CSR_PULSE_LOW:    pulse_low_in    = csr_pwdata[11:0];
            jsm_pkg::CSR_PULSE_CENTRE: pulse_centre_in = csr_pwdata[11:0];
            jsm_pkg::CSR_PULSE_HIGH:   pulse_high_in   = csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_band_ff    <= jsm_pkg::DEAD_BAND_RST;
         pulse_low_ff    <= jsm_pkg::PULSE_LOW_RST;
         pulse_centre_ff <= jsm_pkg::PULSE_CENTRE_RST;
         pulse_high_ff   <= jsm_pkg::PULSE_HIGH_RST;
      end else begin
         dead_band_ff    <= dead_band_in;
         pulse_low_ff    <= pulse_low_in;
         pulse_centre_ff <= pulse_centre_in;
         pulse_high_ff   <= pulse_high_in;
      end
   end

   // Read back, zero-extended.
   always_comb begin
      unique case (csr_index)
         jsm_pkg::CSR_DEAD_BAND:    csr_prdata = {25'd0, dead_band_ff};
         jsm_pkg::CSR_PULSE_LOW:    csr_prdata = {20'd0, pulse_low_ff};
         jsm_pkg::CSR_PULSE_CENTRE: csr_prdata = {20'd0, pulse_centre_ff};
         jsm_pkg::CSR_PULSE_HIGH:   csr_prdata = {20'd0, pulse_high_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline control: each stage loads when it is empty or its word
   // moves on in the same cycle, so bubbles squeeze out under stall.
   // ---------------------------------------------------------------
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s3_valid_ff, s3_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 s1_load;
   jsm_pkg::jsm_adv_type adv;

   assign adv.s4  = !rsp_valid_ff || rsp_ready;
   assign adv.s3  = !s3_valid_ff || adv.s4;
   assign adv.s2  = !s2_valid_ff || adv.s3;
   assign s1_load = !s1_valid_ff || adv.s2;

   assign req_ready = s1_load;
   assign rsp_valid = rsp_valid_ff;

   // Advance valid bits with their stage, hold them otherwise.
   assign s1_valid_in  = s1_load ? req_valid    : s1_valid_ff;
   assign s2_valid_in  = adv.s2  ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in  = adv.s3  ? s2_valid_ff  : s3_valid_ff;
   assign rsp_valid_in = adv.s4  ? s3_valid_ff  : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Datapath: one decode, four wheel scalers.
   // ---------------------------------------------------------------
   jsm_pkg::jsm_term_type [3:0] terms;

   jsm_decode u_decode (
      .clock            (clock),
      .load             (s1_load),
      .left_horizontal  (req_left_horizontal),
      .left_vertical    (req_left_vertical),
      .right_horizontal (req_right_horizontal),
      .force_stop       (req_force_stop),
      .dead_band        (dead_band_ff),
      .terms_ff         (terms)
   );

   // terms[3] is front left down to terms[0] back right.
   jsm_wheel_scale u_front_left (
      .clock        (clock),
      .adv          (adv),
      .term         (terms[3]),
      .pulse_low    (pulse_low_ff),
      .pulse_centre (pulse_centre_ff),
      .pulse_high   (pulse_high_ff),
      .wheel_ff     (rsp_wheel_front_left)
   );

   jsm_wheel_scale u_front_right (
      .clock        (clock),
      .adv          (adv),
      .term         (terms[2]),
      .pulse_low    (pulse_low_ff),
      .pulse_centre (pulse_centre_ff),
      .pulse_high   (pulse_high_ff),
      .wheel_ff     (rsp_wheel_front_right)
   );

   jsm_wheel_scale u_back_left (
      .clock        (clock),
      .adv          (adv),
      .term         (terms[1]),
      .pulse_low    (pulse_low_ff),
      .pulse_centre (pulse_centre_ff),
      .pulse_high   (pulse_high_ff),
      .wheel_ff     (rsp_wheel_back_left)
   );

   jsm_wheel_scale u_back_right (
      .clock        (clock),
      .adv          (adv),
      .term         (terms[0]),
      .pulse_low    (pulse_low_ff),
      .pulse_centre (pulse_centre_ff),
      .pulse_high   (pulse_high_ff),
      .wheel_ff     (rsp_wheel_back_right)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // Input back-pressure only when every stage holds a word.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff))
      else $error("input stalled with an empty stage");

   // A word waiting behind a stalled output stays in stage 3.
   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && rsp_valid_ff && !rsp_ready) |=> s3_valid_ff)
      else $error("stage 3 word lost under output stall");

   // A freshly loaded result lies within the clamp window.
   a_clamp_window: assert property (@(posedge clock) disable iff (reset)
      (adv.s4 && s3_valid_ff && (pulse_low_ff <= pulse_high_ff)) |=>
         (rsp_wheel_front_left  >= $past(pulse_low_ff) &&
          rsp_wheel_front_left  <= $past(pulse_high_ff) &&
          rsp_wheel_front_right >= $past(pulse_low_ff) &&
          rsp_wheel_front_right <= $past(pulse_high_ff) &&
          rsp_wheel_back_left   >= $past(pulse_low_ff) &&
          rsp_wheel_back_left   <= $past(pulse_high_ff) &&
          rsp_wheel_back_right  >= $past(pulse_low_ff) &&
          rsp_wheel_back_right  <= $past(pulse_high_ff)))
      else $error("wheel pulse outside clamp window");

endmodule
